// ----- rtl/yuv2rgb_pkg.sv -----
// ----------------------------------------------------------------------------
// yuv2rgb_pkg
// shared constants and coefficient helper for the yuyv to rgb888 converter
// ----------------------------------------------------------------------------
package yuv2rgb_pkg;

	// default number of fraction bits in the chroma coefficients
	localparam int COEF_FRAC_BITS_DEF = 14;

	// coefficients in millionths
	localparam int unsigned MICRO_R_V = 1370705;
	localparam int unsigned MICRO_G_U = 698001;
	localparam int unsigned MICRO_G_V = 703125;
	localparam int unsigned MICRO_B_U = 1732446;

	localparam longint unsigned MICRO_ONE  = 1000000;
	localparam longint unsigned MICRO_HALF = 500000;

	// saturated channel ceiling
	localparam logic [7:0] CHANNEL_MAX = 8'hFF;

	// unsigned fixed-point coefficient, rounded to nearest
	function automatic longint unsigned coef_q(input int unsigned micro, input int frac);
		longint unsigned scaled;
		scaled = longint'(micro) << frac;
		return (scaled + MICRO_HALF) / MICRO_ONE;
	endfunction

endpackage

// ----- rtl/yuv2rgb_chroma.sv -----
// ----------------------------------------------------------------------------
// yuv2rgb_chroma
// constant-coefficient chroma products shared by both pixels of a pair
// ----------------------------------------------------------------------------
module yuv2rgb_chroma #(
	parameter int COEF_FRAC_BITS = yuv2rgb_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic [7:0]                       chroma_blue,
	input  logic [7:0]                       chroma_red,
	output logic signed [COEF_FRAC_BITS+9:0] term_r,
	output logic signed [COEF_FRAC_BITS+9:0] term_b,
	output logic signed [COEF_FRAC_BITS+10:0] term_g
);
	localparam int CW = COEF_FRAC_BITS + 2;
	localparam int PW = COEF_FRAC_BITS + 10;

	localparam logic signed [CW-1:0] C_RV =
		CW'(yuv2rgb_pkg::coef_q(yuv2rgb_pkg::MICRO_R_V, COEF_FRAC_BITS));
	localparam logic signed [CW-1:0] C_GU =
		CW'(yuv2rgb_pkg::coef_q(yuv2rgb_pkg::MICRO_G_U, COEF_FRAC_BITS));
	localparam logic signed [CW-1:0] C_GV =
		CW'(yuv2rgb_pkg::coef_q(yuv2rgb_pkg::MICRO_G_V, COEF_FRAC_BITS));
	localparam logic signed [CW-1:0] C_BU =
		CW'(yuv2rgb_pkg::coef_q(yuv2rgb_pkg::MICRO_B_U, COEF_FRAC_BITS));

	logic signed [7:0]    du;
	logic signed [7:0]    dv;
	logic signed [PW-1:0] prod_gu;
	logic signed [PW-1:0] prod_gv;

	// remove the 128 offset: flipping the top bit gives the two's complement value
	assign du = signed'({~chroma_blue[7], chroma_blue[6:0]});
	assign dv = signed'({~chroma_red[7], chroma_red[6:0]});

	assign term_r  = PW'(C_RV * dv);
	assign term_b  = PW'(C_BU * du);
	assign prod_gu = PW'(C_GU * du);
	assign prod_gv = PW'(C_GV * dv);
	assign term_g  = (PW+1)'(prod_gu) + (PW+1)'(prod_gv);

endmodule

// ----- rtl/yuv2rgb_pixel.sv -----
// ----------------------------------------------------------------------------
// yuv2rgb_pixel
// adds luma to the chroma terms and saturates the three channels of one pixel
// ----------------------------------------------------------------------------
module yuv2rgb_pixel #(
	parameter int COEF_FRAC_BITS = yuv2rgb_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic [7:0]                        luma,
	input  logic signed [COEF_FRAC_BITS+9:0]  term_r,
	input  logic signed [COEF_FRAC_BITS+9:0]  term_b,
	input  logic signed [COEF_FRAC_BITS+10:0] term_g,
	output logic [7:0]                        red,
	output logic [7:0]                        green,
	output logic [7:0]                        blue
);
	localparam int F  = COEF_FRAC_BITS;
	localparam int SW = COEF_FRAC_BITS + 11;

	logic signed [SW-1:0] base;
	logic signed [SW-1:0] sum_r;
	logic signed [SW-1:0] sum_g;
	logic signed [SW-1:0] sum_b;

	// negative clips to zero, integer part above 255 clips to 255
	function automatic logic [7:0] saturate(input logic signed [SW-1:0] sum);
		logic [7:0] res;
		if (sum[SW-1]) begin
			res = '0;
		end else if (|sum[SW-2:F+8]) begin
			res = yuv2rgb_pkg::CHANNEL_MAX;
		end else begin
			res = sum[F+7:F];
		end
		return res;
	endfunction

	assign base  = signed'({3'b000, luma, {F{1'b0}}});
	assign sum_r = base + SW'(term_r);
	assign sum_g = base - SW'(term_g);
	assign sum_b = base + SW'(term_b);

	assign red   = saturate(sum_r);
	assign green = saturate(sum_g);
	assign blue  = saturate(sum_b);

endmodule

// ----- rtl/yuyv_to_rgb888_converter_top.sv -----
// ----------------------------------------------------------------------------
// yuyv_to_rgb888_converter_top
// one yuyv macropixel in, two rgb888 pixels out, one item per clock
// ----------------------------------------------------------------------------
// usage
//  - input channel: drive luma_first, chroma_blue, luma_second, chroma_red and
//    raise start; the item is taken at the clock edge where start is high and
//    busy is low. busy is held low, so an item can be given every cycle
//  - result channel: done is high for exactly one cycle with the six channel
//    bytes alongside; the receiver must take them in that cycle
//  - path: an accepted item passes through the input register and then the
//    result register before done goes high
//  - throughput: one item per clock, set by the single pass from the input
//    register through the chroma products, the luma adders and the clamps
//  - each channel is Y plus (for green, minus) constant chroma products in signed
//    fixed point with COEF_FRAC_BITS fraction bits, truncated and clamped to 0..255
//  - reset (arst_n low) clears the valid flags; no result is pending after it
//  - the receiver cannot stall, so no backpressure path exists
// ----------------------------------------------------------------------------
module yuyv_to_rgb888_converter_top #(
	parameter int COEF_FRAC_BITS = yuv2rgb_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [7:0] luma_first,
	input  logic [7:0] chroma_blue,
	input  logic [7:0] luma_second,
	input  logic [7:0] chroma_red,
	output logic       done,
	output logic [7:0] red_first,
	output logic [7:0] green_first,
	output logic [7:0] blue_first,
	output logic [7:0] red_second,
	output logic [7:0] green_second,
	output logic [7:0] blue_second
);
	// input register stage
	logic       valid_s1;
	logic [7:0] luma_first_s1;
	logic [7:0] chroma_blue_s1;
	logic [7:0] luma_second_s1;
	logic [7:0] chroma_red_s1;

	// shared chroma terms
	logic signed [COEF_FRAC_BITS+9:0]  term_r;
	logic signed [COEF_FRAC_BITS+9:0]  term_b;
	logic signed [COEF_FRAC_BITS+10:0] term_g;

	// combinational pixel results
	logic [7:0] red_a, green_a, blue_a;
	logic [7:0] red_b, green_b, blue_b;

	// result register stage
	logic       valid_s2;
	logic [7:0] red_first_s2, green_first_s2, blue_first_s2;
	logic [7:0] red_second_s2, green_second_s2, blue_second_s2;

	// never stalls: a new item every cycle
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	// payload captured on every accepted item
	always_ff @(posedge clk) begin
		if (start) begin
			luma_first_s1  <= luma_first;
			chroma_blue_s1 <= chroma_blue;
			luma_second_s1 <= luma_second;
			chroma_red_s1  <= chroma_red;
		end
	end

	// chroma products computed once and shared by both pixels
	yuv2rgb_chroma #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_chroma (
		.chroma_blue(chroma_blue_s1),
		.chroma_red (chroma_red_s1),
		.term_r     (term_r),
		.term_b     (term_b),
		.term_g     (term_g)
	);

	// first pixel of the pair
	yuv2rgb_pixel #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_pixel_first (
		.luma  (luma_first_s1),
		.term_r(term_r),
		.term_b(term_b),
		.term_g(term_g),
		.red   (red_a),
		.green (green_a),
		.blue  (blue_a)
	);

	// second pixel of the pair
	yuv2rgb_pixel #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_pixel_second (
		.luma  (luma_second_s1),
		.term_r(term_r),
		.term_b(term_b),
		.term_g(term_g),
		.red   (red_b),
		.green (green_b),
		.blue  (blue_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	// result register, loaded when the input stage holds an item
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			red_first_s2    <= red_a;
			green_first_s2  <= green_a;
			blue_first_s2   <= blue_a;
			red_second_s2   <= red_b;
			green_second_s2 <= green_b;
			blue_second_s2  <= blue_b;
		end
	end

	// result ports, valid for the one cycle that done marks
	assign done         = valid_s2;
	assign red_first    = red_first_s2;
	assign green_first  = green_first_s2;
	assign blue_first   = blue_first_s2;
	assign red_second   = red_second_s2;
	assign green_second = green_second_s2;
	assign blue_second  = blue_second_s2;

endmodule
